// File: sv/dks_pkg.sv
package dks_pkg;

    localparam int KEY_BITS   = 64;
    localparam int HALF_BITS  = 28;
    localparam int CD_BITS    = 56;
    localparam int SUB_BITS   = 48;
    localparam int NUM_ROUNDS = 16;
    localparam int ROUND_BITS = 4;

    typedef logic [ROUND_BITS-1:0] t_round;
    typedef logic [HALF_BITS-1:0]  t_half;
    typedef logic [CD_BITS-1:0]    t_cd;
    typedef logic [SUB_BITS-1:0]   t_sub;
    typedef logic [KEY_BITS-1:0]   t_key;

    typedef struct packed {
        t_round round;
        logic   last;
    } t_beat;

    localparam t_round LAST_ROUND = t_round'(NUM_ROUNDS - 1);

    // set where the round rotates by two places
    localparam logic [NUM_ROUNDS-1:0] ROT_TWO = 16'h7EFC;

    localparam byte unsigned PC1_TAB [CD_BITS] = '{
        8'd57, 8'd49, 8'd41, 8'd33, 8'd25, 8'd17, 8'd9,  8'd1,  8'd58, 8'd50,
        8'd42, 8'd34, 8'd26, 8'd18, 8'd10, 8'd2,  8'd59, 8'd51, 8'd43, 8'd35,
        8'd27, 8'd19, 8'd11, 8'd3,  8'd60, 8'd52, 8'd44, 8'd36, 8'd63, 8'd55,
        8'd47, 8'd39, 8'd31, 8'd23, 8'd15, 8'd7,  8'd62, 8'd54, 8'd46, 8'd38,
        8'd30, 8'd22, 8'd14, 8'd6,  8'd61, 8'd53, 8'd45, 8'd37, 8'd29, 8'd21,
        8'd13, 8'd5,  8'd28, 8'd20, 8'd12, 8'd4
    };

    localparam byte unsigned PC2_TAB [SUB_BITS] = '{
        8'd14, 8'd17, 8'd11, 8'd24, 8'd1,  8'd5,  8'd3,  8'd28, 8'd15, 8'd6,
        8'd21, 8'd10, 8'd23, 8'd19, 8'd12, 8'd4,  8'd26, 8'd8,  8'd16, 8'd7,
        8'd27, 8'd20, 8'd13, 8'd2,  8'd41, 8'd52, 8'd31, 8'd37, 8'd47, 8'd55,
        8'd30, 8'd40, 8'd51, 8'd45, 8'd33, 8'd48, 8'd44, 8'd49, 8'd39, 8'd56,
        8'd34, 8'd53, 8'd46, 8'd42, 8'd50, 8'd36, 8'd29, 8'd32
    };

    // bit 1 of each numbering is the msb
    function automatic t_cd pc1(input t_key key);
        t_cd res;
        res = '0;
        for (int i = 0; i < CD_BITS; i++) begin
            res[CD_BITS-1-i] = key[KEY_BITS - int'(PC1_TAB[i])];
        end
        return res;
    endfunction

    function automatic t_sub pc2(input t_cd cd);
        t_sub res;
        res = '0;
        for (int i = 0; i < SUB_BITS; i++) begin
            res[SUB_BITS-1-i] = cd[CD_BITS - int'(PC2_TAB[i])];
        end
        return res;
    endfunction

endpackage

// File: sv/dks_pc1_stage.sv
module dks_pc1_stage (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_ready,
    input  dks_pkg::t_key  i_key,
    output logic           o_valid,
    input  logic           i_take,
    output dks_pkg::t_cd   o_cd
);

    logic         r_valid;
    dks_pkg::t_cd r_cd;

    assign o_ready = !r_valid || i_take;
    assign o_valid = r_valid;
    assign o_cd    = r_cd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
        if (o_ready && i_valid) begin
            r_cd <= dks_pkg::pc1(i_key);
        end
    end

endmodule

// File: sv/dks_round_seq.sv
module dks_round_seq (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_take,
    input  dks_pkg::t_cd     i_cd,
    output logic             o_valid,
    input  logic             i_ready,
    output dks_pkg::t_cd     o_cd,
    output dks_pkg::t_beat   o_beat
);

    logic            r_busy;
    dks_pkg::t_round r_round;
    dks_pkg::t_half  r_c;
    dks_pkg::t_half  r_d;

    dks_pkg::t_half  rot_c;
    dks_pkg::t_half  rot_d;
    logic            advance;
    logic            at_last;

    always_comb begin
        if (dks_pkg::ROT_TWO[r_round]) begin
            rot_c = {r_c[dks_pkg::HALF_BITS-3:0], r_c[dks_pkg::HALF_BITS-1 -: 2]};
            rot_d = {r_d[dks_pkg::HALF_BITS-3:0], r_d[dks_pkg::HALF_BITS-1 -: 2]};
        end else begin
            rot_c = {r_c[dks_pkg::HALF_BITS-2:0], r_c[dks_pkg::HALF_BITS-1]};
            rot_d = {r_d[dks_pkg::HALF_BITS-2:0], r_d[dks_pkg::HALF_BITS-1]};
        end
    end

    assign at_last     = (r_round == dks_pkg::LAST_ROUND);
    assign advance     = r_busy && i_ready;
    assign o_take      = !r_busy || (advance && at_last);
    assign o_valid     = r_busy;
    assign o_cd        = {rot_c, rot_d};
    assign o_beat.round = r_round;
    assign o_beat.last  = at_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy  <= 1'b0;
            r_round <= '0;
        end else if (o_take) begin
            r_busy  <= i_valid;
            r_round <= '0;
        end else if (advance) begin
            r_round <= r_round + 1'b1;
        end
        if (o_take && i_valid) begin
            r_c <= i_cd[dks_pkg::CD_BITS-1:dks_pkg::HALF_BITS];
            r_d <= i_cd[dks_pkg::HALF_BITS-1:0];
        end else if (advance) begin
            r_c <= rot_c;
            r_d <= rot_d;
        end
    end

    a_hold_round: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy && !i_ready |=> r_busy && $stable(r_round))
        else $error("round moved while stalled");

    a_step_round: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        advance && !at_last |=> r_busy && r_round == $past(r_round) + 1'b1)
        else $error("round did not step by one");

    a_load_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_take && i_valid |=> r_busy && r_round == '0)
        else $error("new key did not start at round zero");

endmodule

// File: sv/dks_pc2_stage.sv
module dks_pc2_stage (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_ready,
    input  dks_pkg::t_cd     i_cd,
    input  dks_pkg::t_beat   i_beat,
    output logic             o_valid,
    input  logic             i_stall,
    output dks_pkg::t_sub    o_subkey,
    output dks_pkg::t_beat   o_beat
);

    logic            r_valid;
    dks_pkg::t_sub   r_subkey;
    dks_pkg::t_beat  r_beat;

    assign o_ready  = !r_valid || !i_stall;
    assign o_valid  = r_valid;
    assign o_subkey = r_subkey;
    assign o_beat   = r_beat;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
        if (o_ready && i_valid) begin
            r_subkey <= dks_pkg::pc2(i_cd);
            r_beat   <= i_beat;
        end
    end

endmodule

// File: sv/des_key_schedule_unit.sv
// a key passes the pc1 register, the round sequencer register and the pc2 register on its way out
// throughput: one subkey per cycle while i_stall is low; the pace of keys is set by the round
// sequencer, which walks the sixteen rotations of one key through a single register
// a following key waits in the pc1 register and starts with no gap
// reset clears the valid bits and the round counter only
module des_key_schedule_unit (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_valid,
    output logic                           o_stall,
    input  logic [dks_pkg::KEY_BITS-1:0]   i_key,
    output logic                           o_valid,
    input  logic                           i_stall,
    output logic [dks_pkg::ROUND_BITS-1:0] o_round,
    output logic [dks_pkg::SUB_BITS-1:0]   o_subkey,
    output logic                           o_last
);

    logic           in_ready;
    logic           pc1_valid;
    logic           seq_take;
    dks_pkg::t_cd   pc1_cd;
    logic           seq_valid;
    logic           pc2_ready;
    dks_pkg::t_cd   seq_cd;
    dks_pkg::t_beat seq_beat;
    dks_pkg::t_beat out_beat;

    assign o_stall = !in_ready;

    dks_pc1_stage u_pc1 (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (in_ready),
        .i_key   (i_key),
        .o_valid (pc1_valid),
        .i_take  (seq_take),
        .o_cd    (pc1_cd)
    );

    dks_round_seq u_seq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (pc1_valid),
        .o_take  (seq_take),
        .i_cd    (pc1_cd),
        .o_valid (seq_valid),
        .i_ready (pc2_ready),
        .o_cd    (seq_cd),
        .o_beat  (seq_beat)
    );

    dks_pc2_stage u_pc2 (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (seq_valid),
        .o_ready  (pc2_ready),
        .i_cd     (seq_cd),
        .i_beat   (seq_beat),
        .o_valid  (o_valid),
        .i_stall  (i_stall),
        .o_subkey (o_subkey),
        .o_beat   (out_beat)
    );

    assign o_round = out_beat.round;
    assign o_last  = out_beat.last;

    a_last_round: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_last |-> o_round == dks_pkg::LAST_ROUND)
        else $error("last flag off the final round");

endmodule
